// File: rtl/fir_pkg.sv
// Shared types, sizes and helpers for the direct-form FIR filter.
// No dependencies; every other file imports this package.
package fir_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CFG_W       = 6;
  localparam int IDX_W       = 5;
  localparam int TAPS_RESET  = 21;

  localparam int TAP_IW = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int ZCNT_W = $clog2(MAX_RESULTS + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + TAP_IW + 1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZERO,
    ST_MAC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              shift_en;
    logic              coef_we;
    logic              mul_en;
    logic [TAP_IW-1:0] mul_idx;
    logic              acc_en;
    logic              acc_first;
    logic              out_load;
    logic              out_zero;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Tap count in use: zero reads as one, anything above the line length saturates.
  function automatic logic [CNT_W-1:0] taps_in_use(input logic [CFG_W-1:0] n);
    logic [CNT_W-1:0] t;
    if (n == '0) begin
      t = CNT_W'(1);
    end else if (int'(n) > MAX_TAPS) begin
      t = CNT_W'(MAX_TAPS);
    end else begin
      t = CNT_W'(n);
    end
    return t;
  endfunction

endpackage

// File: rtl/fir_if.sv
// Valid/ready channel interfaces for the FIR filter: sample/coefficient in, result out.
// Depends on fir_pkg for field widths.
interface fir_in_if;
  import fir_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [IDX_W-1:0]              coef_index;
  logic signed [SAMPLE_BITS-1:0] coef_value;

  modport source (output valid, operation, sample, coef_index, coef_value, input ready);
  modport sink   (input valid, operation, sample, coef_index, coef_value, output ready);
endinterface

interface fir_out_if;
  import fir_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          last;

  modport source (output valid, filtered, last, input ready);
  modport sink   (input valid, filtered, last, output ready);
endinterface

// File: rtl/fir_ctrl.sv
// Controller for the FIR filter: tap-count register, fill tracking and sequencing
// of leading zeros, serial MAC and result emission. Depends on fir_pkg.
module fir_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [fir_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  fir_pkg::stat_t               stat,
  output fir_pkg::cmd_t                cmd
);
  import fir_pkg::*;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   num_taps_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               primed_r, primed_nxt;
  logic [ZCNT_W-1:0]  zcnt_r, zcnt_nxt;
  logic               has_out_r, has_out_nxt;
  logic [CNT_W-1:0]   mcnt_r, mcnt_nxt;

  logic [CNT_W-1:0]   taps;
  logic [CNT_W-1:0]   fill_inc;
  logic [CNT_W-1:0]   half_taps;
  logic [ZCNT_W-1:0]  zeros;
  logic               hit;
  logic               accept;

  assign taps      = taps_in_use(num_taps_r);
  assign fill_inc  = (int'(fill_r) == MAX_TAPS) ? fill_r : fill_r + CNT_W'(1);
  assign hit       = (fill_inc >= taps);
  assign half_taps = taps >> 1;
  assign zeros     = primed_r ? '0 :
                     (int'(half_taps) > MAX_RESULTS) ? ZCNT_W'(MAX_RESULTS) :
                     ZCNT_W'(half_taps);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      num_taps_r <= CFG_W'(TAPS_RESET);
      fill_r     <= '0;
      primed_r   <= 1'b0;
      zcnt_r     <= '0;
      has_out_r  <= 1'b0;
      mcnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      primed_r  <= primed_nxt;
      zcnt_r    <= zcnt_nxt;
      has_out_r <= has_out_nxt;
      mcnt_r    <= mcnt_nxt;
      if (cfg_wr_en) begin
        num_taps_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    primed_nxt  = primed_r;
    zcnt_nxt    = zcnt_r;
    has_out_nxt = has_out_r;
    mcnt_nxt    = mcnt_r;
    in_ready    = 1'b0;
    cmd         = '0;

    case (state_r)
      ST_IDLE: begin
        // no transaction is taken while reset is held
        in_ready = rst_n;
        if (accept) begin
          if (in_operation == OP_COEF) begin
            cmd.coef_we = 1'b1;
          end else begin
            cmd.shift_en = 1'b1;
            primed_nxt   = 1'b1;
            fill_nxt     = hit ? taps - CNT_W'(1) : fill_inc;
            has_out_nxt  = hit;
            zcnt_nxt     = zeros;
            mcnt_nxt     = '0;
            if (zeros != '0) begin
              state_nxt = ST_ZERO;
            end else if (hit) begin
              state_nxt = ST_MAC;
            end
          end
        end
      end

      ST_ZERO: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = 1'b1;
          cmd.out_last = (zcnt_r == ZCNT_W'(1)) && !has_out_r;
          zcnt_nxt     = zcnt_r - ZCNT_W'(1);
          if (zcnt_r == ZCNT_W'(1)) begin
            state_nxt = has_out_r ? ST_MAC : ST_IDLE;
          end
        end
      end

      // issue tap mcnt while accumulating the product of the previous tap
      ST_MAC: begin
        cmd.mul_en    = (mcnt_r < taps);
        cmd.mul_idx   = mcnt_r[TAP_IW-1:0];
        cmd.acc_en    = (mcnt_r != '0);
        cmd.acc_first = (mcnt_r == CNT_W'(1));
        mcnt_nxt      = mcnt_r + CNT_W'(1);
        if (mcnt_r == taps) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fir_dp.sv
// Datapath for the FIR filter: delay line, coefficient store, registered multiplier,
// accumulator, round/saturate and the output register. Depends on fir_pkg.
module fir_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fir_pkg::cmd_t                        cmd,
  output fir_pkg::stat_t                       stat,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic [fir_pkg::IDX_W-1:0]            in_coef_index,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] in_coef_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fir_pkg::SAMPLE_BITS-1:0] out_filtered,
  output logic                                 out_last
);
  import fir_pkg::*;

  localparam logic signed [ACC_W:0] SAT_HI  = (ACC_W+1)'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [ACC_W:0] SAT_LO  = -SAT_HI - (ACC_W+1)'(1);
  localparam logic signed [ACC_W:0] RND_ADD = (ACC_W+1)'(1) << (SAMPLE_BITS - 2);

  logic signed [SAMPLE_BITS-1:0] dl_r   [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coef_r [MAX_TAPS];
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_filtered_r;
  logic                          out_last_r;

  logic [TAP_IW+IDX_W-1:0]       idx_wide;
  logic signed [ACC_W:0]         rnd;
  logic signed [ACC_W:0]         shifted;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign idx_wide = {{TAP_IW{1'b0}}, in_coef_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        dl_r[i]   <= '0;
        coef_r[i] <= '0;
      end
    end else begin
      if (cmd.shift_en) begin
        dl_r[0] <= in_sample;
        for (int i = 1; i < MAX_TAPS; i++) begin
          dl_r[i] <= dl_r[i-1];
        end
      end
      if (cmd.coef_we && (int'(in_coef_index) < MAX_TAPS)) begin
        coef_r[idx_wide[TAP_IW-1:0]] <= in_coef_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= coef_r[cmd.mul_idx] * dl_r[cmd.mul_idx];
    end
    if (cmd.acc_en) begin
      acc_r <= cmd.acc_first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, floor shift, then clamp to the sample range
  assign rnd     = {acc_r[ACC_W-1], acc_r} + RND_ADD;
  assign shifted = rnd >>> (SAMPLE_BITS - 1);
  assign sat     = (shifted > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                   (shifted < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] :
                   shifted[SAMPLE_BITS-1:0];

  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_filtered_r <= cmd.out_zero ? '0 : sat;
      out_last_r     <= cmd.out_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_last     = out_last_r;

endmodule

// File: rtl/fir_filter_direct_form_top.sv
// Channel      | Dir | Payload                                    | Handshake
// in_if        | in  | operation, sample, coef_index, coef_value  | valid/ready
// out_if       | out | filtered, last                             | valid/ready
// cfg_wr_*     | in  | num_taps (6 bits)                          | write enable only
//
// Coefficient write: taken in the idle state. Sample: taken in the idle state, then the
// leading zeros are sent (first sample only); once the line holds num_taps samples, a serial
// multiply-accumulate runs on the single multiplier and the result is loaded for output.
// Reset is synchronous, active low; delay line and coefficients clear under reset.
// A stalled output holds the sequencer; a new item is taken while the result waits.
//
// Top level of the direct-form FIR filter; depends on fir_pkg, fir_if, fir_ctrl, fir_dp.
module fir_filter_direct_form_top (
  input  logic                      clk,
  input  logic                      rst_n,
  fir_in_if.sink                    in_if,
  fir_out_if.source                 out_if,
  input  logic                      cfg_wr_en,
  input  logic [fir_pkg::CFG_W-1:0] cfg_wr_data
);
  import fir_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fir_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_operation (in_if.operation),
    .stat         (stat),
    .cmd          (cmd)
  );

  fir_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_sample     (in_if.sample),
    .in_coef_index (in_if.coef_index),
    .in_coef_value (in_if.coef_value),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_filtered  (out_if.filtered),
    .out_last      (out_if.last)
  );

endmodule

// File: rtl/fir_chk.sv
// Port-level checks on the FIR filter result channel, bound to the top level.
// Depends on fir_pkg and fir_filter_direct_form_top.
module fir_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [fir_pkg::SAMPLE_BITS-1:0] out_filtered,
  input logic                                 out_last
);
  import fir_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only leading zeros are ever sent without last
  a_zero_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_filtered == '0)
    else $error("non-final result is not a leading zero");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_filtered) && $stable(out_last))
    else $error("result payload changed while stalled");

endmodule

bind fir_filter_direct_form_top fir_chk u_fir_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_filtered (out_if.filtered),
  .out_last     (out_if.last)
);

// File: tb/sv/fir_filter_direct_form_top_test.sv
// Self-checking bench for fir_filter_direct_form_top: coefficient writes and audio samples
// under random gaps and stalls, checked against an in-bench filter predictor.
// Depends on fir_pkg and the fir_in_if / fir_out_if channel interfaces.
module fir_filter_direct_form_top_test;
  import fir_pkg::*;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 18;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          last;
  } fir_result_t;

  // Tracks filter state and the queue of outputs still owed by the block.
  class fir_output_tracker;
    logic [CFG_W-1:0]              cfg_taps;
    logic signed [SAMPLE_BITS-1:0] taps_line [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] coefs [MAX_TAPS];
    int                            fill;
    bit                            primed;
    int                            errors;
    fir_result_t                   expected_outputs [$];

    function new();
      cfg_taps = CFG_W'(TAPS_RESET);
      foreach (taps_line[k]) begin
        taps_line[k] = '0;
        coefs[k]     = '0;
      end
      fill   = 0;
      primed = 1'b0;
      errors = 0;
    endfunction

    function void note_item(logic op, logic signed [SAMPLE_BITS-1:0] smp,
                            logic [IDX_W-1:0] idx, logic signed [SAMPLE_BITS-1:0] cv);
      int          taps;
      int          zeros;
      int          cnt;
      longint      acc;
      fir_result_t r;
      if (op == OP_COEF) begin
        coefs[idx] = cv;
        return;
      end
      taps = (cfg_taps == 0) ? 1 : ((int'(cfg_taps) > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps));
      cnt  = 0;
      if (!primed) begin
        zeros = taps / 2;
        if (zeros > MAX_RESULTS) zeros = MAX_RESULTS;
        r.filtered = '0;
        r.last     = 1'b0;
        for (int z = 0; z < zeros; z++) begin
          expected_outputs.insert(expected_outputs.size(), r);
          cnt++;
        end
        primed = 1'b1;
      end
      for (int k = MAX_TAPS - 1; k > 0; k--) taps_line[k] = taps_line[k-1];
      taps_line[0] = smp;
      if (fill < MAX_TAPS) fill++;
      if (fill >= taps && cnt < MAX_RESULTS) begin
        acc = 0;
        for (int k = 0; k < taps; k++) acc += longint'(coefs[k]) * longint'(taps_line[k]);
        // round half up, then floor shift back to Q1.15
        acc = (acc + (longint'(1) << (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        r.filtered = acc[SAMPLE_BITS-1:0];
        r.last     = 1'b0;
        expected_outputs.insert(expected_outputs.size(), r);
        cnt++;
        fill = taps - 1;
      end
      if (cnt > 0) expected_outputs[expected_outputs.size()-1].last = 1'b1;
    endfunction

    function void check_output(logic signed [SAMPLE_BITS-1:0] f, logic l);
      fir_result_t want;
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected output filtered=%0d last=%0b", $time, f, l);
        return;
      end
      want = expected_outputs[0];
      expected_outputs.delete(0);
      if (f !== want.filtered) begin
        errors++;
        $display("%0t: filtered expected %0d actual %0d", $time, want.filtered, f);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, l);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  bit               tx_idle;
  int               results_seen;
  int               quiet_cycles;
  fir_output_tracker predictor;

  fir_in_if  in_ch();
  fir_out_if out_ch();

  fir_filter_direct_form_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Full-range values half the time, with extremes and small magnitudes mixed in.
  function automatic logic signed [SAMPLE_BITS-1:0] rand_q15();
    logic signed [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2, 3: v = SAMPLE_BITS'($signed($urandom_range(0, 512)) - 256);
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_item(input logic op, input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic [IDX_W-1:0] idx,
                           input logic signed [SAMPLE_BITS-1:0] cv);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.sample     <= smp;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= cv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predictor.note_item(op, smp, idx, cv);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (predictor.expected_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_taps(input logic [CFG_W-1:0] n);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    predictor.cfg_taps = n;
  endtask

  // Result side: random stall before each transaction, in alternating stretches.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    results_seen = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = ((results_seen / 25) % 2 == 0) ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      predictor.check_output(out_ch.filtered, out_ch.last);
      results_seen++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("fir_filter_direct_form_top_test: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int tap_settings [9];
    predictor        = new();
    tx_idle          = 1'b1;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_SAMPLE;
    in_ch.sample     = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: index extremes at the reset tap count.
    send_item(OP_COEF, 16'sh0000, 5'd31, 16'sh8000);
    send_item(OP_COEF, 16'sh7fff, 5'd0,  16'sh7fff);
    send_item(OP_COEF, 16'sh0000, 5'd1,  16'sh8000);
    // Above the line length: 32 taps, so sixteen leading zeros and no filter output.
    write_taps(6'd63);
    send_item(OP_SAMPLE, 16'sh7fff, 5'd0, 16'sh0000);
    // Two taps: near cancellation to one LSB, then positive and negative saturation.
    write_taps(6'd2);
    send_item(OP_COEF, 16'sh0000, 5'd0, 16'sh8000);
    send_item(OP_SAMPLE, 16'sh8000, 5'd0, 16'sh0000);
    send_item(OP_SAMPLE, 16'sh8000, 5'd0, 16'sh0000);
    send_item(OP_COEF, 16'sh0000, 5'd0, 16'sh7fff);
    send_item(OP_COEF, 16'sh0000, 5'd1, 16'sh7fff);
    send_item(OP_SAMPLE, 16'sh8000, 5'd0, 16'sh0000);
    // Zero taps reads as one: rounding at the half and just past it.
    write_taps(6'd0);
    send_item(OP_COEF, 16'sh0000, 5'd0, 16'sh0001);
    send_item(OP_SAMPLE, 16'sh4000, 5'd0, 16'sh0000);
    send_item(OP_SAMPLE, -16'sh4000, 5'd0, 16'sh0000);
    send_item(OP_SAMPLE, -16'sh4001, 5'd0, 16'sh0000);
    send_item(OP_SAMPLE, 16'sh0000, 5'd0, 16'sh0000);

    tap_settings = '{1, 32, 5, 21, 0, 63, 3, 16, 0};
    tap_settings[8] = $urandom_range(1, 32);
    foreach (tap_settings[p]) begin
      write_taps(CFG_W'(tap_settings[p]));
      tx_idle = (p % 3 != 2);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) < 3) begin
          send_item(OP_COEF, SAMPLE_BITS'($urandom), IDX_W'($urandom), rand_q15());
        end else begin
          send_item(OP_SAMPLE, rand_q15(), IDX_W'($urandom), SAMPLE_BITS'($urandom));
        end
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    wait_drained();
    if (predictor.errors == 0 && predictor.expected_outputs.size() == 0) begin
      $display("fir_filter_direct_form_top_test: done, clean");
    end else begin
      $display("fir_filter_direct_form_top_test: done, errors");
    end
    $finish;
  end

endmodule
